// ===== rtl/core/ntt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_pkg
// Shared constants and types of the NTT block.
// ----------------------------------------------------------------------------
package ntt_pkg;

	localparam logic [29:0] PRIME = 30'd998244353;

	localparam int CFG_INVERSE    = 0;
	localparam int CFG_LOG_LENGTH = 1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_BREV,
		ST_BFLY,
		ST_SCALE,
		ST_EMIT
	} state_t;

	// Forward twiddle roots 3^((p-1)/2^s) for s = 1..12; indexed by s.
	function automatic logic [29:0] root_fwd(input logic [3:0] s);
		case (s)
			4'd1:    root_fwd = 30'd998244352;
			4'd2:    root_fwd = 30'd911660635;
			4'd3:    root_fwd = 30'd372528824;
			4'd4:    root_fwd = 30'd929031873;
			4'd5:    root_fwd = 30'd452798380;
			4'd6:    root_fwd = 30'd922799308;
			4'd7:    root_fwd = 30'd781712469;
			4'd8:    root_fwd = 30'd476477967;
			4'd9:    root_fwd = 30'd166035806;
			4'd10:   root_fwd = 30'd258648936;
			4'd11:   root_fwd = 30'd584193783;
			4'd12:   root_fwd = 30'd63912897;
			default: root_fwd = 30'd1;
		endcase
	endfunction

	function automatic logic [29:0] root_inv(input logic [3:0] s);
		case (s)
			4'd1:    root_inv = 30'd998244352;
			4'd2:    root_inv = 30'd86583718;
			4'd3:    root_inv = 30'd509520358;
			4'd4:    root_inv = 30'd337190230;
			4'd5:    root_inv = 30'd87557064;
			4'd6:    root_inv = 30'd609441965;
			4'd7:    root_inv = 30'd135236158;
			4'd8:    root_inv = 30'd304459705;
			4'd9:    root_inv = 30'd685443576;
			4'd10:   root_inv = 30'd381598368;
			4'd11:   root_inv = 30'd335559352;
			4'd12:   root_inv = 30'd129292727;
			default: root_inv = 30'd1;
		endcase
	endfunction

	// n^-1 mod p for n = 2^lg
	function automatic logic [29:0] len_inv(input logic [3:0] lg);
		case (lg)
			4'd1:    len_inv = 30'd499122177;
			4'd2:    len_inv = 30'd748683265;
			4'd3:    len_inv = 30'd873463809;
			4'd4:    len_inv = 30'd935854081;
			4'd5:    len_inv = 30'd967049217;
			4'd6:    len_inv = 30'd982646785;
			4'd7:    len_inv = 30'd990445569;
			4'd8:    len_inv = 30'd994344961;
			4'd9:    len_inv = 30'd996294657;
			4'd10:   len_inv = 30'd997269505;
			4'd11:   len_inv = 30'd997756929;
			4'd12:   len_inv = 30'd998000641;
			default: len_inv = 30'd1;
		endcase
	endfunction

endpackage

// ===== rtl/core/ntt_mulmod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_mulmod
// Pipelined a*b mod p, Barrett reduction of the 60-bit product.
// ----------------------------------------------------------------------------
module ntt_mulmod (
	input  logic        clk,
	input  logic [29:0] a,
	input  logic [29:0] b,
	output logic [29:0] p
);
	// floor(2^60 / p)
	localparam logic [30:0] MU = 31'd1154949187;

	logic [59:0] prod_s1;
	logic [61:0] q_s2;
	logic [31:0] x_lo_s2;
	logic [31:0] r_s3;
	logic [29:0] r_s4;
	logic [31:0] qp;
	logic [31:0] r1;

	always_ff @(posedge clk) begin
		prod_s1 <= 60'(a) * 60'(b);
	end

	// quotient estimate from the top 31 product bits
	always_ff @(posedge clk) begin
		q_s2 <= 62'(prod_s1[59:29]) * 62'(MU);
		x_lo_s2 <= prod_s1[31:0];
	end

	// remainder is below 3p, so the low 32 bits are exact
	assign qp = 32'(q_s2[61:31]) * 32'(ntt_pkg::PRIME);

	always_ff @(posedge clk) begin
		r_s3 <= x_lo_s2 - qp;
	end

	assign r1 = (r_s3 >= 32'(ntt_pkg::PRIME)) ? r_s3 - 32'(ntt_pkg::PRIME) : r_s3;

	always_ff @(posedge clk) begin
		r_s4 <= (r1 >= 32'(ntt_pkg::PRIME)) ? 30'(r1 - 32'(ntt_pkg::PRIME)) : r1[29:0];
	end

	assign p = r_s4;
endmodule

// ===== rtl/core/number_theoretic_transform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_theoretic_transform
// Radix-2 NTT modulo 998244353, up to MAX_POINTS points.
// Input beats (residue_in) are stored one per cycle. The beat that completes
// a block of 2^log_length values starts the transform: a bit-reverse pass,
// log2(n) butterfly passes, an optional 1/n scaling pass, then n output beats
// in index order with final_res on the last. Each memory access is serialized
// through the single coefficient memory and a 4-stage modular multiplier:
// bit reversal swaps one pair at a time, a butterfly reads both points and
// writes both results in turn, scaling handles one point at a time and each
// output beat waits on its own memory read. No input is taken while the
// transform or emission runs. A stall on the output holds the current beat.
// Reset clears the load count, the state and the registers (inverse 0,
// log_length 6); memory contents are not cleared.
// Configuration: cfg_valid/cfg_ready, cfg_index, cfg_data; always ready.
// ----------------------------------------------------------------------------
module number_theoretic_transform #(
	parameter int MAX_POINTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [29:0] residue_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [29:0] residue_out,
	output logic [5:0]  position,
	output logic        final_res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [2:0]  cfg_data
);
	localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
	localparam int TOP = $clog2(MAX_POINTS + 1) - 1;

	ntt_pkg::state_t state_q;
	logic        inv_q;
	logic [2:0]  lgreg_q;
	logic [AW:0] cnt_q;
	logic [3:0]  lg_q;
	logic [AW:0] i_q;
	logic [3:0]  sub_q;
	logic [3:0]  s_q;
	logic [AW:0] j_q;
	logic [29:0] w_q, wn_q, u_q, v_q, t_q;
	logic [29:0] mem [MAX_POINTS];
	logic [29:0] rd_q;
	logic [AW-1:0] ra, wa;
	logic [29:0] wd;
	logic        we;
	logic [29:0] ma, mb, mp;
	logic [3:0]  lg_eff;
	logic [AW:0] n_eff, n_q;
	logic [AW-1:0] rev;
	logic [AW:0] half, ka, kb;
	logic [29:0] red_in;
	logic [30:0] sum, dif;

	ntt_mulmod u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

	always_comb begin
		lg_eff = {1'b0, lgreg_q};
		if (lg_eff < 4'd1) lg_eff = 4'd1;
		if (lg_eff > 4'(TOP)) lg_eff = 4'(TOP);
		n_eff = (AW + 1)'(1) << lg_eff;
		n_q = (AW + 1)'(1) << lg_q;
	end

	always_comb begin
		rev = '0;
		for (int b = 0; b < AW; b++)
			if (b < int'(lg_q)) rev[int'(lg_q) - 1 - b] = i_q[b];
	end

	assign red_in = (residue_in >= ntt_pkg::PRIME) ? residue_in - ntt_pkg::PRIME : residue_in;
	assign half = (AW + 1)'(1) << (s_q - 4'd1);
	// butterfly pair: j_q enumerates n/2 pairs; insert a zero at bit s-1
	assign ka = ((j_q >> (s_q - 4'd1)) << s_q) | (j_q & (half - 1'b1));
	assign kb = ka + half;
	assign sum = {1'b0, u_q} + {1'b0, mp};
	// t_q holds w*x[kb]: the multiplier output, registered
	assign dif = {1'b0, u_q} + {1'b0, ntt_pkg::PRIME} - {1'b0, t_q};

	assign in_stall = (state_q != ntt_pkg::ST_LOAD);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	// sequencer, control outputs
	always_comb begin
		ra = '0; wa = '0; wd = '0; we = 1'b0; ma = w_q; mb = rd_q;
		case (state_q)
			ntt_pkg::ST_LOAD: begin
				we = in_valid; wa = cnt_q[AW-1:0]; wd = red_in;
			end
			ntt_pkg::ST_BREV: begin
				case (sub_q)
					4'd0: ra = i_q[AW-1:0];
					4'd1: ra = rev;
					4'd2: begin we = 1'b1; wa = i_q[AW-1:0]; wd = rd_q; end
					4'd3: begin we = 1'b1; wa = rev; wd = u_q; end
					default: ;
				endcase
			end
			ntt_pkg::ST_BFLY: begin
				case (sub_q)
					4'd0: ra = kb[AW-1:0];
					4'd1: ra = ka[AW-1:0];
					4'd5: begin we = 1'b1; wa = ka[AW-1:0];
						wd = (sum >= 31'(ntt_pkg::PRIME)) ? 30'(sum - 31'(ntt_pkg::PRIME)) : sum[29:0];
					end
					4'd6: begin we = 1'b1; wa = kb[AW-1:0];
						wd = (dif >= 31'(ntt_pkg::PRIME)) ? 30'(dif - 31'(ntt_pkg::PRIME)) : dif[29:0];
					end
					default: ;
				endcase
				if (sub_q == 4'd1) begin ma = w_q; mb = rd_q; end
				if (sub_q == 4'd6 || sub_q == 4'd7) begin ma = w_q; mb = wn_q; end
			end
			ntt_pkg::ST_SCALE: begin
				ra = i_q[AW-1:0]; ma = rd_q; mb = ntt_pkg::len_inv(lg_q);
				if (sub_q == 4'd5) begin we = 1'b1; wa = i_q[AW-1:0]; wd = mp; end
			end
			ntt_pkg::ST_EMIT: ra = i_q[AW-1:0];
			default: ;
		endcase
	end

	logic [29:0] out_d_q;
	logic [AW:0] out_pos_q;
	logic        out_last_q;
	logic        out_v_q;
	assign out_valid = out_v_q;
	assign residue_out = out_d_q;
	assign position = 6'(out_pos_q);
	assign final_res = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ntt_pkg::ST_LOAD;
			inv_q <= 1'b0; lgreg_q <= 3'd6; cnt_q <= '0; lg_q <= 4'd1;
			i_q <= '0; sub_q <= '0; s_q <= 4'd1; j_q <= '0; out_v_q <= 1'b0;
			w_q <= '0; wn_q <= '0; u_q <= '0; t_q <= '0;
			out_d_q <= '0; out_pos_q <= '0; out_last_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == 1'(ntt_pkg::CFG_INVERSE)) inv_q <= cfg_data[0];
				else lgreg_q <= cfg_data;
			end
			case (state_q)
				ntt_pkg::ST_LOAD: begin
					if (in_valid) begin
						if (cnt_q + 1'b1 >= n_eff) begin
							cnt_q <= '0; lg_q <= lg_eff; i_q <= '0; sub_q <= '0;
							state_q <= ntt_pkg::ST_BREV;
						end else cnt_q <= cnt_q + 1'b1;
					end
				end
				ntt_pkg::ST_BREV: begin
					if (sub_q == 4'd0 && !({1'b0, rev} > i_q)) begin
						if (i_q == n_q - 1'b1) begin
							state_q <= ntt_pkg::ST_BFLY; s_q <= 4'd1; j_q <= '0;
							w_q <= 30'd1;
							wn_q <= inv_q ? ntt_pkg::root_inv(4'd1) : ntt_pkg::root_fwd(4'd1);
						end
						i_q <= i_q + 1'b1;
					end else begin
						if (sub_q == 4'd1) u_q <= rd_q;
						if (sub_q == 4'd3) begin
							sub_q <= '0;
							if (i_q == n_q - 1'b1) begin
								state_q <= ntt_pkg::ST_BFLY; s_q <= 4'd1; j_q <= '0;
								w_q <= 30'd1;
								wn_q <= inv_q ? ntt_pkg::root_inv(4'd1) : ntt_pkg::root_fwd(4'd1);
							end
							i_q <= i_q + 1'b1;
						end else sub_q <= sub_q + 1'b1;
					end
				end
				ntt_pkg::ST_BFLY: begin
					if (sub_q == 4'd2) u_q <= rd_q;
					if (sub_q == 4'd5) t_q <= mp;
					if (sub_q == 4'd10) begin
						w_q <= mp;
						sub_q <= '0;
						if (j_q == (n_q >> 1) - 1'b1) begin
							j_q <= '0; w_q <= 30'd1;
							if (s_q == lg_q) begin
								i_q <= '0;
								state_q <= inv_q ? ntt_pkg::ST_SCALE : ntt_pkg::ST_EMIT;
							end else begin
								s_q <= s_q + 4'd1;
								wn_q <= inv_q ? ntt_pkg::root_inv(s_q + 4'd1)
								              : ntt_pkg::root_fwd(s_q + 4'd1);
							end
						end else begin
							j_q <= j_q + 1'b1;
							if (((j_q + 1'b1) & (half - 1'b1)) == '0) w_q <= 30'd1;
						end
					end else sub_q <= sub_q + 1'b1;
				end
				ntt_pkg::ST_SCALE: begin
					if (sub_q == 4'd5) begin
						sub_q <= '0;
						if (i_q == n_q - 1'b1) begin
							i_q <= '0; state_q <= ntt_pkg::ST_EMIT;
						end else i_q <= i_q + 1'b1;
					end else sub_q <= sub_q + 1'b1;
				end
				ntt_pkg::ST_EMIT: begin
					if (!out_v_q || !out_stall) begin
						if (sub_q == 4'd0) begin
							sub_q <= 4'd1; out_v_q <= 1'b0;
						end else begin
							out_v_q <= 1'b1; out_d_q <= rd_q; out_pos_q <= i_q;
							out_last_q <= (i_q == n_q - 1'b1);
							sub_q <= '0;
							if (i_q == n_q - 1'b1) state_q <= ntt_pkg::ST_LOAD;
							i_q <= i_q + 1'b1;
						end
					end
				end
				default: state_q <= ntt_pkg::ST_LOAD;
			endcase
			if (state_q != ntt_pkg::ST_EMIT && out_v_q && !out_stall) out_v_q <= 1'b0;
		end
	end
endmodule
